// ===== design/bship_pkg.sv =====
// Shared widths, register indexes, microcode and arithmetic helpers for the escape iterator.
package bship_pkg;

    localparam int WORD_W      = 32;
    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 16;
    localparam int MAG_W       = WORD_W - 1;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int SQ_W        = PROD_W - FRAC_BITS;
    localparam int RI2_W       = SQ_W + 1;
    localparam int SUM_W       = SQ_W + 1;
    localparam int EXT_W       = RI2_W + 2;
    localparam int ESC_W       = 31;
    localparam int CFG_W       = ESC_W;
    localparam int STEP_W      = 3;

    localparam logic [COUNT_WIDTH-1:0] ITER_LIMIT_RESET = COUNT_WIDTH'(100);
    localparam logic [ESC_W-1:0]       ESC_LIMIT_RESET  = ESC_W'(64'd6 << FRAC_BITS);

    typedef logic [STEP_W-1:0] step_t;

    // Configuration register indexes.
    localparam logic REG_ITER_LIMIT = 1'b0;
    localparam logic REG_ESC_LIMIT  = 1'b1;

    // Microprogram addresses.
    localparam step_t ST_IDLE = 3'd0;
    localparam step_t ST_MAG  = 3'd1;
    localparam step_t ST_MRR  = 3'd2;
    localparam step_t ST_MII  = 3'd3;
    localparam step_t ST_MRI  = 3'd4;
    localparam step_t ST_UPD  = 3'd5;
    localparam step_t ST_FIN  = 3'd6;

    typedef enum logic [1:0] {
        MUL_OFF,
        MUL_RR,
        MUL_II,
        MUL_RI
    } mul_sel_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NEVER,
        C_NO_INPUT,
        C_LIMIT,
        C_ESCAPE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     ld_c;
        logic     ld_mag;
        logic     ld_r2;
        logic     ld_i2;
        logic     upd_z;
        logic     ld_out;
        cond_t    cond;
        step_t    jump;
        step_t    next;
    } ctrl_t;

    // One control word per step. When the condition holds the sequencer goes to
    // jump, otherwise to next.
    function automatic ctrl_t ucode(step_t s);
        ctrl_t w;
        w = '{mul_sel: MUL_OFF, ld_c: 1'b0, ld_mag: 1'b0, ld_r2: 1'b0, ld_i2: 1'b0,
              upd_z: 1'b0, ld_out: 1'b0, cond: C_ALWAYS, jump: ST_IDLE, next: ST_IDLE};
        case (s)
            ST_IDLE:
            begin
                w.ld_c = 1'b1;
                w.cond = C_NO_INPUT;
                w.jump = ST_IDLE;
                w.next = ST_MAG;
            end
            ST_MAG:
            begin
                w.ld_mag = 1'b1;
                w.cond   = C_LIMIT;
                w.jump   = ST_FIN;
                w.next   = ST_MRR;
            end
            ST_MRR:
            begin
                w.mul_sel = MUL_RR;
                w.cond    = C_NEVER;
                w.next    = ST_MII;
            end
            ST_MII:
            begin
                w.mul_sel = MUL_II;
                w.ld_r2   = 1'b1;
                w.cond    = C_NEVER;
                w.next    = ST_MRI;
            end
            ST_MRI:
            begin
                w.mul_sel = MUL_RI;
                w.ld_i2   = 1'b1;
                w.cond    = C_ESCAPE;
                w.jump    = ST_FIN;
                w.next    = ST_UPD;
            end
            ST_UPD:
            begin
                w.upd_z = 1'b1;
                w.cond  = C_ALWAYS;
                w.jump  = ST_MAG;
            end
            ST_FIN:
            begin
                w.ld_out = 1'b1;
                w.cond   = C_OUT_BUSY;
                w.jump   = ST_FIN;
                w.next   = ST_IDLE;
            end
            default:
            begin
                w.cond = C_ALWAYS;
                w.jump = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // Magnitude of a signed word, with the most negative word reading as the largest positive.
    function automatic logic [MAG_W-1:0] mag_sat(logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] a;
        a = v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
        if (a[WORD_W-1])
        begin
            return {MAG_W{1'b1}};
        end
        return a[MAG_W-1:0];
    endfunction

    // Clamp a wide signed value into the signed word range.
    function automatic logic [WORD_W-1:0] sat_word(logic [EXT_W-1:0] v);
        logic [EXT_W-WORD_W:0] top;
        top = v[EXT_W-1:WORD_W-1];
        if (top == '0 || top == '1)
        begin
            return v[WORD_W-1:0];
        end
        return v[EXT_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

endpackage

// ===== design/burning_ship_escape_iteration.sv =====
// Burning Ship escape-time iterator driven by a microcoded sequencer over one shared multiplier.
//
// One beat is taken in the idle step; every round that does not escape runs the magnitude,
// three product and update steps in turn. A point that reaches the limit goes to the finish
// step from the limit check that follows its last round; an escaping point goes there from
// the r*i step of its escaping round. The finish step holds while the output is stalled,
// and a new point is taken only once the sequencer is back in idle. The single 31x31
// multiplier is used three times in turn by each round.
// Reset clears the sequencer and output valid and loads iteration_limit = 100 and
// escape_limit = 6.0.
module burning_ship_escape_iteration
    import bship_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [2*WORD_W-1:0]    s_tdata,   // point_real [31:0], point_imag [63:32]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [COUNT_WIDTH-1:0] m_tdata,   // iteration_count [15:0]
    output logic [0:0]             m_tuser,   // escaped [0]
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    // Configuration registers.
    logic [COUNT_WIDTH-1:0] iter_limit_reg;
    logic [ESC_W-1:0]       esc_limit_reg;

    // Sequencer state.
    step_t step_reg, step_next;
    ctrl_t ctrl;
    logic  cond_hit;

    // Datapath registers.
    logic [WORD_W-1:0]      c_real_reg, c_imag_reg;
    logic [WORD_W-1:0]      z_real_reg, z_imag_reg;
    logic [MAG_W-1:0]       r_reg, i_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [SQ_W-1:0]        r2_reg, i2_reg;
    logic [COUNT_WIDTH-1:0] round_reg;
    logic                   esc_reg;

    // Output register.
    logic                   out_valid_reg;
    logic [COUNT_WIDTH-1:0] out_count_reg;
    logic                   out_esc_reg;

    logic                   in_beat;
    logic                   out_busy;
    logic                   limit_hit;
    logic                   escape_hit;
    logic [SUM_W-1:0]       mag_sum;
    logic [SQ_W-1:0]        sq_now;
    logic [RI2_W-1:0]       ri2_now;
    logic [EXT_W-1:0]       z_real_wide, z_imag_wide;
    logic [MAG_W-1:0]       mul_a, mul_b;

    assign ctrl     = ucode(step_reg);
    assign s_tready = ctrl.ld_c;
    assign in_beat  = s_tvalid && s_tready;
    assign out_busy = out_valid_reg && !m_tready;

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_count_reg;
    assign m_tuser[0] = out_esc_reg;

    // The loop ends before a round starts once the round count reaches the limit;
    // a zero limit therefore runs no rounds.
    assign limit_hit = (round_reg >= iter_limit_reg);

    // In the r*i step the product register holds i*i, so the escape test sees the
    // full-width sum of both squares in the same cycle that i2 is stored.
    assign sq_now     = prod_reg[PROD_W-1:FRAC_BITS];
    assign mag_sum    = {1'b0, r2_reg} + {1'b0, sq_now};
    assign escape_hit = (mag_sum > SUM_W'(esc_limit_reg));

    // In the update step the product register holds r*i; doubling and scaling
    // collapse into one shift that keeps an extra bit.
    assign ri2_now = prod_reg[PROD_W-1:FRAC_BITS-1];

    assign z_real_wide = EXT_W'({3'b000, r2_reg}) - EXT_W'({3'b000, i2_reg})
                       + {{(EXT_W-WORD_W){c_real_reg[WORD_W-1]}}, c_real_reg};
    assign z_imag_wide = EXT_W'({2'b00, ri2_now})
                       + {{(EXT_W-WORD_W){c_imag_reg[WORD_W-1]}}, c_imag_reg};

    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_RR:
            begin
                mul_a = r_reg;
                mul_b = r_reg;
            end
            MUL_II:
            begin
                mul_a = i_reg;
                mul_b = i_reg;
            end
            MUL_RI:
            begin
                mul_a = r_reg;
                mul_b = i_reg;
            end
            default:
            begin
                mul_a = r_reg;
                mul_b = i_reg;
            end
        endcase
    end

    always_comb
    begin
        case (ctrl.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_NEVER:    cond_hit = 1'b0;
            C_NO_INPUT: cond_hit = !s_tvalid;
            C_LIMIT:    cond_hit = limit_hit;
            C_ESCAPE:   cond_hit = escape_hit;
            C_OUT_BUSY: cond_hit = out_busy;
            default:    cond_hit = 1'b1;
        endcase
        step_next = cond_hit ? ctrl.jump : ctrl.next;
    end

    // Control state, configuration and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= ST_IDLE;
            iter_limit_reg <= ITER_LIMIT_RESET;
            esc_limit_reg  <= ESC_LIMIT_RESET;
            round_reg      <= '0;
            esc_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ITER_LIMIT: iter_limit_reg <= cfg_data[COUNT_WIDTH-1:0];
                    REG_ESC_LIMIT:  esc_limit_reg  <= cfg_data[ESC_W-1:0];
                    default:        ;
                endcase
            end

            if (in_beat)
            begin
                round_reg <= '0;
                esc_reg   <= 1'b0;
            end
            else if (ctrl.upd_z)
            begin
                round_reg <= round_reg + COUNT_WIDTH'(1);
            end
            else if (ctrl.ld_i2 && escape_hit)
            begin
                esc_reg <= 1'b1;
            end

            if (ctrl.ld_out && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            c_real_reg <= s_tdata[WORD_W-1:0];
            c_imag_reg <= s_tdata[2*WORD_W-1:WORD_W];
            z_real_reg <= s_tdata[WORD_W-1:0];
            z_imag_reg <= s_tdata[2*WORD_W-1:WORD_W];
        end
        else if (ctrl.upd_z)
        begin
            z_real_reg <= sat_word(z_real_wide);
            z_imag_reg <= sat_word(z_imag_wide);
        end

        if (ctrl.ld_mag)
        begin
            r_reg <= mag_sat(z_real_reg);
            i_reg <= mag_sat(z_imag_reg);
        end

        if (ctrl.mul_sel != MUL_OFF)
        begin
            prod_reg <= mul_a * mul_b;
        end

        if (ctrl.ld_r2)
        begin
            r2_reg <= sq_now;
        end

        if (ctrl.ld_i2)
        begin
            i2_reg <= sq_now;
        end

        if (ctrl.ld_out && !out_busy)
        begin
            out_count_reg <= round_reg;
            out_esc_reg   <= esc_reg;
        end
    end

    // An escaped point always stops short of the round limit.
    a_escape_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata < iter_limit_reg))
        else $error("escaped result with a count at or above the limit");

    // A point that never escaped reports exactly the round limit.
    a_inside_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == iter_limit_reg))
        else $error("non-escaped result with a count other than the limit");

    // The round count never runs past the limit while a point is in flight.
    a_round_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != ST_IDLE) |-> (round_reg <= iter_limit_reg))
        else $error("round counter passed the iteration limit");

    // A new point is only taken in the idle step, never while rounds are running.
    a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (step_reg == ST_MAG && round_reg == '0 && !esc_reg))
        else $error("point accepted without a clean start of the iteration");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the Burning Ship escape iterator: stream stimulus plus a result checker.
`timescale 1ns / 100ps

typedef struct packed {
    logic [bship_pkg::COUNT_WIDTH-1:0] count;
    logic                              escaped;
} escape_result_t;

class escape_count_checker;
    int unsigned      iter_limit;
    longint unsigned  esc_limit;
    escape_result_t   awaited_counts[$];
    int               errors;

    function new();
        iter_limit = bship_pkg::ITER_LIMIT_RESET;
        esc_limit  = bship_pkg::ESC_LIMIT_RESET;
        errors     = 0;
    endfunction

    function void write_reg(logic idx, logic [bship_pkg::CFG_W-1:0] value);
        if (idx == bship_pkg::REG_ITER_LIMIT)
            iter_limit = value[bship_pkg::COUNT_WIDTH-1:0];
        else
            esc_limit = value;
    endfunction

    // Absolute value, with the most negative word reading as the largest positive one.
    function longint unsigned magnitude(longint signed v);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        if (m > 64'd2147483647)
            m = 64'd2147483647;
        return m;
    endfunction

    function longint signed clamp_word(longint signed v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Runs one point to completion and returns the round count and escape flag.
    function escape_result_t iterate_point(logic signed [31:0] c_re, logic signed [31:0] c_im);
        longint signed   cr;
        longint signed   ci;
        longint signed   zr;
        longint signed   zi;
        longint unsigned r;
        longint unsigned i;
        longint unsigned r2;
        longint unsigned i2;
        longint unsigned ri2;
        int unsigned     round;
        logic            hit;
        escape_result_t  res;
        cr    = c_re;
        ci    = c_im;
        zr    = cr;
        zi    = ci;
        round = 0;
        hit   = 1'b0;
        while (!hit && round < iter_limit)
        begin
            r   = magnitude(zr);
            i   = magnitude(zi);
            r2  = (r * r) >> bship_pkg::FRAC_BITS;
            i2  = (i * i) >> bship_pkg::FRAC_BITS;
            ri2 = ((r * i) << 1) >> bship_pkg::FRAC_BITS;
            if (r2 + i2 > esc_limit)
            begin
                hit = 1'b1;
            end
            else
            begin
                zr = clamp_word(longint'(r2) - longint'(i2) + cr);
                zi = clamp_word(longint'(ri2) + ci);
                round++;
            end
        end
        res.count   = round[bship_pkg::COUNT_WIDTH-1:0];
        res.escaped = hit;
        return res;
    endfunction

    function void note_point(logic [31:0] re, logic [31:0] im);
        awaited_counts.push_back(iterate_point(re, im));
    endfunction

    function void check_result(logic [bship_pkg::COUNT_WIDTH-1:0] count, logic escaped);
        escape_result_t want;
        if (awaited_counts.size() == 0)
        begin
            $display("%0t: unexpected result beat, count %0d escaped %0d",
                     $time, count, escaped);
            errors++;
            return;
        end
        want = awaited_counts.pop_front();
        if (count !== want.count)
        begin
            $display("%0t: iteration_count expected %0d actual %0d", $time, want.count, count);
            errors++;
        end
        if (escaped !== want.escaped)
        begin
            $display("%0t: escaped expected %0d actual %0d", $time, want.escaped, escaped);
            errors++;
        end
    endfunction

    function int pending();
        return awaited_counts.size();
    endfunction
endclass

module tb;
    import bship_pkg::*;

    // Handy Q4.28 values used by the directed points.
    localparam logic [31:0] Q_ZERO  = 32'h0000_0000;
    localparam logic [31:0] Q_ONE   = 32'h1000_0000;
    localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN   = 32'h8000_0000;
    localparam logic [31:0] Q_SQRT8 = 32'h2D41_3CCC;
    localparam logic [ESC_W-1:0] ESC_MAX = 31'h7FFF_FFFF;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [2*WORD_W-1:0]    s_tdata   = '0;   // point_real [31:0], point_imag [63:32]
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [COUNT_WIDTH-1:0] m_tdata;          // iteration_count [15:0]
    logic [0:0]             m_tuser;          // escaped [0]
    logic                   cfg_we    = 1'b0;
    logic                   cfg_index = REG_ITER_LIMIT;
    logic [CFG_W-1:0]       cfg_data  = '0;

    // Percent chance, per cycle, that the sender holds back or the receiver stalls.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    escape_count_checker counts;

    burning_ship_escape_iteration i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offers one point and returns at the edge where the beat is taken. The valid line
    // is left high so that a following point can go out back to back; the idle loop
    // lowers it when a gap is wanted.
    task automatic send_point(input logic [31:0] re, input logic [31:0] im);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        counts.note_point(re, im);
    endtask

    // Waits until every point sent so far has produced its result. Each point gives
    // exactly one result, so once the queue is empty the block is back in idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (counts.pending() != 0)
            @(posedge clk);
    endtask

    // Writes the iteration limit, then the escape threshold; only called while the block is idle.
    task automatic load_limits(input logic [COUNT_WIDTH-1:0] limit,
                               input logic [ESC_W-1:0] esc);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ITER_LIMIT;
        cfg_data  <= CFG_W'(limit);
        @(posedge clk);
        counts.write_reg(REG_ITER_LIMIT, CFG_W'(limit));
        cfg_index <= REG_ESC_LIMIT;
        cfg_data  <= esc;
        @(posedge clk);
        counts.write_reg(REG_ESC_LIMIT, esc);
        cfg_we <= 1'b0;
    endtask

    // Mostly coordinates within plus or minus two, where the interesting dynamics live, with some
    // raw words and corner values mixed in so every data bit toggles.
    function automatic logic [31:0] pick_coord();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return 32'($urandom_range(32'h4000_0000)) - 32'h2000_0000;
        if (sel < 85)
            return $urandom();
        case ($urandom_range(7))
            0: return Q_ZERO;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return Q_MAX;
            4: return Q_MIN;
            5: return 32'h8000_0001;
            6: return Q_ONE;
            default: return 32'hF000_0000;
        endcase
    endfunction

    // Limits stay small for most phases so that points that never escape stay cheap.
    function automatic logic [COUNT_WIDTH-1:0] pick_limit();
        case ($urandom_range(3))
            0: return COUNT_WIDTH'($urandom_range(1, 12));
            1: return COUNT_WIDTH'($urandom_range(13, 64));
            2: return ITER_LIMIT_RESET;
            default: return COUNT_WIDTH'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic logic [ESC_W-1:0] pick_escape();
        case ($urandom_range(4))
            0: return ESC_LIMIT_RESET;
            1: return ESC_MAX;
            2: return '0;
            3: return ESC_W'($urandom());
            default: return ESC_W'($urandom_range(32'h4000_0000));
        endcase
    endfunction

    // Result side: checks every accepted beat and redraws tready each cycle.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                counts.check_result(m_tdata, m_tuser[0]);
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Main sequence: reset, directed points, then randomized phases.
    initial
    begin
        counts = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points at the reset settings (limit 100, threshold 6.0).
        send_idle_pct = 12;
        stall_pct     = 12;
        send_point(Q_ZERO, Q_ZERO);             // stays at the origin for the full limit
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN);               // magnitude of the most negative word saturates
        send_point(Q_MIN, Q_ZERO);
        send_point(Q_ZERO, Q_MIN);
        send_point(Q_MAX, Q_MIN);
        send_point(Q_ONE, Q_ZERO);              // escapes after a couple of rounds
        send_point(32'hE400_0000, 32'hFF80_0000);
        send_point(32'hFFFF_FFFF, 32'h0000_0001);
        send_point(32'hF800_0000, 32'hF800_0000);
        drain();

        // Largest threshold lets z grow far enough that the update has to clamp:
        // the first point overflows the real part, the second the imaginary part.
        load_limits(ITER_LIMIT_RESET, ESC_MAX);
        send_point(Q_SQRT8, Q_ZERO);
        send_point(32'h1FC0_0000, 32'h1FC0_0000);
        send_point(Q_MAX, Q_ZERO);
        drain();

        // A zero threshold: only points whose squares truncate to zero survive.
        load_limits(COUNT_WIDTH'(3), '0);
        send_point(Q_ZERO, Q_ZERO);
        send_point(32'h0000_0001, Q_ZERO);
        send_point(32'h0001_0000, Q_ZERO);
        drain();

        // A limit of zero runs no rounds at all.
        load_limits('0, ESC_LIMIT_RESET);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_ZERO, Q_ZERO);
        drain();

        load_limits(COUNT_WIDTH'(1), ESC_LIMIT_RESET);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_ONE, Q_ONE);
        drain();

        // Full-scale limit; the origin point walks the counter all the way to the top.
        load_limits('1, ESC_LIMIT_RESET);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_ONE, Q_ZERO);
        drain();

        // Random phases, rotating through the four flow-control patterns.
        for (int p = 0; p < 16; p++)
        begin
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 58;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 58;
                end
                default:
                begin
                    send_idle_pct = 12;
                    stall_pct     = 12;
                end
            endcase
            load_limits(pick_limit(), pick_escape());
            repeat (110) send_point(pick_coord(), pick_coord());
            drain();
        end

        // Give the block time to show any stray result beat before the verdict.
        repeat (20) @(posedge clk);
        if (counts.errors == 0)
            $display("burning_ship_escape_iteration: match");
        else
            $display("burning_ship_escape_iteration: mismatch");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #80_000_000;
        $display("burning_ship_escape_iteration: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/bship_pkg.sv
design/burning_ship_escape_iteration.sv
verif/tb.sv
